### rtl/trex_pkg.sv
// ----------------------------------------------------------------------------
// trex_pkg
// Shared types and codes of the three-operand execute stage: opcode values,
// status codes and the packed request and result item types.
// ----------------------------------------------------------------------------
package trex_pkg;

	// default configuration
	localparam int DEF_NUM_REGS = 16;
	localparam int DEF_PC_BITS  = 12;

	// fixed field widths
	localparam int OP_W     = 5;
	localparam int RIDX_W   = 4;
	localparam int DATA_W   = 32;
	localparam int NPC_W    = 12;
	localparam int STATUS_W = 2;

	// jump target keeps the low bits of operand c
	localparam int TARGET_W = 12;

	// shift amount is the low bits of operand b
	localparam int SHAMT_W = 5;

	// register 1 and 2 always take the immediates, 0 reads as zero
	localparam int FIRST_GPR = 3;

	// opcodes
	localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
	localparam logic [OP_W-1:0] OP_SUB   = 5'd1;
	localparam logic [OP_W-1:0] OP_MADD  = 5'd2;
	localparam logic [OP_W-1:0] OP_AND   = 5'd3;
	localparam logic [OP_W-1:0] OP_OR    = 5'd4;
	localparam logic [OP_W-1:0] OP_XOR   = 5'd5;
	localparam logic [OP_W-1:0] OP_SLL   = 5'd6;
	localparam logic [OP_W-1:0] OP_SRL   = 5'd7;
	localparam logic [OP_W-1:0] OP_SRA   = 5'd8;
	localparam logic [OP_W-1:0] OP_BEQ   = 5'd9;
	localparam logic [OP_W-1:0] OP_BNE   = 5'd10;
	localparam logic [OP_W-1:0] OP_BLT   = 5'd11;
	localparam logic [OP_W-1:0] OP_BGT   = 5'd12;
	localparam logic [OP_W-1:0] OP_BLE   = 5'd13;
	localparam logic [OP_W-1:0] OP_BGE   = 5'd14;
	localparam logic [OP_W-1:0] OP_JAL   = 5'd15;
	localparam logic [OP_W-1:0] OP_HALT  = 5'd21;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_UNIMPL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ILLEGAL = 2'd2;

	// one decoded instruction
	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic [RIDX_W-1:0]        dest_reg;
		logic [RIDX_W-1:0]        src_a_reg;
		logic [RIDX_W-1:0]        src_b_reg;
		logic [RIDX_W-1:0]        src_c_reg;
		logic signed [DATA_W-1:0] imm_first;
		logic signed [DATA_W-1:0] imm_second;
	} in_item_t;

	// one execute result
	typedef struct packed {
		logic [NPC_W-1:0]         next_pc;
		logic                     write_enable;
		logic [RIDX_W-1:0]        write_reg;
		logic signed [DATA_W-1:0] write_value;
		logic                     halted;
		logic [STATUS_W-1:0]      status;
	} out_item_t;

endpackage

### rtl/three_operand_risc_execute_stage.sv
// ----------------------------------------------------------------------------
// three_operand_risc_execute_stage
// Executes one decoded instruction per transfer against a flop register file
// and program counter, and reports the write, next pc, halt and status.
// ----------------------------------------------------------------------------
// One instruction per clock, sustained while the result side does not stall.
// A transfer lands in an input register; once the result register is free or
// being taken, the whole instruction (operand reads, one 32x32 multiply with
// an add, compare, pc update) resolves in one pass and moves into the result
// register while the register file and pc update at the same edge, so the
// following instruction already sees them. Registers 1 and 2 are loaded with
// the immediates by every instruction before its reads, so reads of them
// return the current immediates directly and they need no storage; register
// 0 reads as zero. Stalls on the result side hold the input register, and
// input ready drops only while both registers are full and the result is not taken.
module three_operand_risc_execute_stage
	import trex_pkg::*;
#(
	parameter int NUM_REGS = DEF_NUM_REGS,
	parameter int PC_BITS  = DEF_PC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int NR_W = (NUM_REGS > (1 << RIDX_W)) ? $clog2(NUM_REGS) + 1 : RIDX_W + 1;

	// pipeline control
	logic     valid_s1;
	in_item_t item_s1;
	logic     advance;
	logic     out_valid_q;
	out_item_t out_q;

	// architectural state
	logic [DATA_W-1:0]  regs_q [FIRST_GPR:NUM_REGS-1];
	logic [PC_BITS-1:0] pc_q;

	// execute signals
	logic [DATA_W-1:0]     opa, opb, opc;
	logic [DATA_W-1:0]     alu_res;
	logic [DATA_W-1:0]     prod;
	logic [SHAMT_W-1:0]    shamt;
	logic                  taken;
	logic [PC_BITS-1:0]    pc_inc;
	logic [PC_BITS-1:0]    target;
	logic [PC_BITS-1:0]    npc;
	logic                  wr_req;
	logic                  we;
	logic [DATA_W-1:0]     wval;
	logic                  halt;
	logic [STATUS_W-1:0]   status;
	logic [PC_BITS+TARGET_W-1:0] target_ext;
	logic [PC_BITS+NPC_W-1:0]    npc_ext;
	logic [PC_BITS+DATA_W-1:0]   link_ext;
	logic [NR_W-1:0]       dest_ext;

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// operand read mux
	function automatic logic [DATA_W-1:0] read_reg(
		input logic [RIDX_W-1:0] idx,
		input logic [DATA_W-1:0] imm1,
		input logic [DATA_W-1:0] imm2,
		input logic [DATA_W-1:0] file [FIRST_GPR:NUM_REGS-1]
	);
		logic [DATA_W-1:0] v;
		v = '0;
		if (idx == RIDX_W'(1)) begin
			v = imm1;
		end else if (idx == RIDX_W'(2)) begin
			v = imm2;
		end else begin
			for (int i = FIRST_GPR; i < NUM_REGS; i++) begin
				if (NR_W'(idx) == NR_W'(i)) begin
					v = file[i];
				end
			end
		end
		return v;
	endfunction

	always_comb begin
		opa = read_reg(item_s1.src_a_reg, item_s1.imm_first, item_s1.imm_second, regs_q);
		opb = read_reg(item_s1.src_b_reg, item_s1.imm_first, item_s1.imm_second, regs_q);
		opc = read_reg(item_s1.src_c_reg, item_s1.imm_first, item_s1.imm_second, regs_q);
	end

	// arithmetic unit, product keeps its low word
	assign shamt = opb[SHAMT_W-1:0];
	assign prod  = opa * opb;

	always_comb begin
		unique case (item_s1.operation)
			OP_ADD:  alu_res = opa + opb + opc;
			OP_SUB:  alu_res = opa - opb - opc;
			OP_MADD: alu_res = prod[DATA_W-1:0] + opc;
			OP_AND:  alu_res = opa & opb & opc;
			OP_OR:   alu_res = opa | opb | opc;
			OP_XOR:  alu_res = opa ^ opb ^ opc;
			OP_SLL:  alu_res = opa << shamt;
			OP_SRL:  alu_res = opa >> shamt;
			default: alu_res = $unsigned($signed(opa) >>> shamt);
		endcase
	end

	// branch compare, signed
	always_comb begin
		unique case (item_s1.operation)
			OP_BEQ:  taken = (opa == opb);
			OP_BNE:  taken = (opa != opb);
			OP_BLT:  taken = ($signed(opa) <  $signed(opb));
			OP_BGT:  taken = ($signed(opa) >  $signed(opb));
			OP_BLE:  taken = ($signed(opa) <= $signed(opb));
			default: taken = ($signed(opa) >= $signed(opb));
		endcase
	end

	// pc arithmetic, wraps within the pc width
	assign pc_inc     = pc_q + PC_BITS'(1);
	assign target_ext = {{PC_BITS{1'b0}}, opc[TARGET_W-1:0]};
	assign target     = target_ext[PC_BITS-1:0];
	assign link_ext   = {{DATA_W{1'b0}}, pc_inc};

	// instruction classes
	always_comb begin
		wr_req = 1'b0;
		wval   = alu_res;
		npc    = pc_q;
		halt   = 1'b0;
		status = STATUS_OK;
		priority if (item_s1.operation <= OP_SRA) begin
			wr_req = 1'b1;
			npc    = pc_inc;
		end else if (item_s1.operation <= OP_BGE) begin
			npc = taken ? target : pc_inc;
		end else if (item_s1.operation == OP_JAL) begin
			wr_req = 1'b1;
			wval   = link_ext[DATA_W-1:0];
			npc    = target;
		end else if (item_s1.operation < OP_HALT) begin
			status = STATUS_UNIMPL;
			npc    = pc_inc;
		end else if (item_s1.operation == OP_HALT) begin
			halt = 1'b1;
		end else begin
			status = STATUS_ILLEGAL;
		end
	end

	// register 0 and out-of-range destinations are never written
	assign dest_ext = NR_W'(item_s1.dest_reg);
	assign we       = wr_req && (item_s1.dest_reg != '0) && (dest_ext < NR_W'(NUM_REGS));
	assign npc_ext  = {{NPC_W{1'b0}}, npc};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			for (int i = FIRST_GPR; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (advance) begin
			pc_q <= npc;
			for (int i = FIRST_GPR; i < NUM_REGS; i++) begin
				if (we && dest_ext == NR_W'(i)) begin
					regs_q[i] <= wval;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.next_pc      <= npc_ext[NPC_W-1:0];
			out_q.write_enable <= we;
			out_q.write_reg    <= we ? item_s1.dest_reg : '0;
			out_q.write_value  <= we ? $signed(wval) : '0;
			out_q.halted       <= halt;
			out_q.status       <= status;
		end
	end

endmodule

### rtl/trex_checker.sv
// ----------------------------------------------------------------------------
// trex_checker
// Port-level checks of the execute stage result stream, bound to the top.
// ----------------------------------------------------------------------------
module trex_checker
	import trex_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a reported write never targets register 0
	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.write_enable |-> out_data.write_reg != '0)
		else $error("write reported to register 0");

	// no write means index and value read as zero
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_enable |->
			out_data.write_reg == '0 && out_data.write_value == '0)
		else $error("write fields not cleared");

	// halt carries ok status and no write
	a_halt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.halted |->
			out_data.status == STATUS_OK && !out_data.write_enable)
		else $error("halt with write or bad status");

	// a transfer while no result is pending is followed by a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && in_data.operation == in_data.operation
			##1 1'b1 |=> out_valid)
		else $error("result missing after transfer");

endmodule

bind three_operand_risc_execute_stage trex_checker u_trex_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
